// File: rtl/bdtq_pkg.sv
// Shared types and constants for the batching drop-tail queue.
// Used by every module of the block; depends on nothing.
`default_nettype none

package bdtq_pkg;

   // Storage geometry
   localparam int QUEUE_DEPTH = 64;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   // Field widths
   localparam int TAG_W      = 16;
   localparam int BYTES_W    = 16;
   localparam int TOTAL_W    = 22;
   localparam int TIME_W     = 32;
   localparam int ACTION_W   = 2;
   localparam int KIND_W     = 3;
   localparam int LIMIT_W    = 7;
   localparam int MEAN_W     = 16;
   localparam int TIMEOUT_W  = 32;
   localparam int BATCH_W    = 24;
   localparam int LIM_W      = LIMIT_W + MEAN_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // Request action codes
   localparam logic [ACTION_W-1:0] ACT_ENQUEUE = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_DEQUEUE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_SHRINK  = 2'd2;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT_PACKETS    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MEAN_PACKET_SIZE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT_IN_BYTES   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DROP_FROM_FRONT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BATCH_TIMEOUT    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BATCH_BYTES      = 3'd5;

   typedef enum logic [1:0] {
      OP_ENQUEUE,
      OP_DEQUEUE,
      OP_SHRINK
   } op_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_ACCEPTED    = 3'd0,
      KIND_DROPPED     = 3'd1,
      KIND_SENT        = 3'd2,
      KIND_DEFERRED    = 3'd3,
      KIND_EMPTY       = 3'd4,
      KIND_SHRINK_DONE = 3'd5
   } kind_type;

   // Command handed from the front to the back
   typedef struct packed {
      op_type              op;
      logic [TAG_W-1:0]    tag;
      logic [BYTES_W-1:0]  bytes;
      logic [TIME_W-1:0]   now_time;
   } cmd_type;

   // Configuration as seen by the back
   typedef struct packed {
      logic [LIMIT_W-1:0]   limit_packets;
      logic                 count_in_bytes;
      logic                 drop_from_front;
      logic [TIMEOUT_W-1:0] batch_timeout;
      logic [BATCH_W-1:0]   batch_bytes;
      logic [LIM_W-1:0]     lim_bytes;
   } cfg_type;

   // One result
   typedef struct packed {
      kind_type            result_kind;
      logic [TAG_W-1:0]    out_tag;
      logic [BYTES_W-1:0]  out_bytes;
      logic                last_of_run;
      logic [CNT_W-1:0]    queue_count;
      logic [TOTAL_W-1:0]  queue_total_bytes;
      logic                timer_request;
   } rsp_type;

endpackage

`default_nettype wire

// File: rtl/batching_drop_tail_queue_top.sv
// Top level of the batching drop-tail packet queue.
// Depends on bdtq_pkg, bdtq_csr, bdtq_front, bdtq_cmd_queue and bdtq_back.
//
//   channel  | handshake           | payload
//   ---------+---------------------+---------------------------------------------
//   req      | push / full         | action, in_tag, in_bytes, now_time
//   rsp      | pop / empty         | result_kind, out_tag, out_bytes, last_of_run,
//            |                     | queue_count, queue_total_bytes, timer_request
//   csr      | valid / ready       | index, data (ready is always high)
//
// Each request is loaded in the idle state, which pops it from the command
// queue and starts the packet-store read, and committed in the exec state. A
// shrink stays in exec as it drops packets, paced by the registered store read.
// The two-entry command queue keeps taking requests while the back end is busy.
// A result that is not popped holds the back end at its commit cycle.
// Reset is synchronous; the packet store is not cleared and needs no sweep.
`default_nettype none

module batching_drop_tail_queue_top import bdtq_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [ACTION_W-1:0]   req_action,
   input  logic [TAG_W-1:0]      req_in_tag,
   input  logic [BYTES_W-1:0]    req_in_bytes,
   input  logic [TIME_W-1:0]     req_now_time,
   // result channel
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [KIND_W-1:0]     rsp_result_kind,
   output logic [TAG_W-1:0]      rsp_out_tag,
   output logic [BYTES_W-1:0]    rsp_out_bytes,
   output logic                  rsp_last_of_run,
   output logic [CNT_W-1:0]      rsp_queue_count,
   output logic [TOTAL_W-1:0]    rsp_queue_total_bytes,
   output logic                  rsp_timer_request,
   // configuration channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type cfg;
   cmd_type push_cmd;
   cmd_type head_cmd;
   rsp_type rsp;
   logic    q_push, q_full, q_pop, q_empty;

   // configuration registers and registered byte limit
   bdtq_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // classify the request and drop undefined actions
   bdtq_front u_front (
      .req_push     (req_push),
      .req_full     (req_full),
      .req_action   (req_action),
      .req_in_tag   (req_in_tag),
      .req_in_bytes (req_in_bytes),
      .req_now_time (req_now_time),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_cmd        (push_cmd)
   );

   // decouple the front from the back
   bdtq_cmd_queue u_cmd_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .head_cmd (head_cmd)
   );

   // execute commands against the packet store
   bdtq_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd_empty (q_empty),
      .cmd_head  (head_cmd),
      .cmd_pop   (q_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp       (rsp)
   );

   // drive the result ports from the result register
   assign rsp_result_kind       = rsp.result_kind;
   assign rsp_out_tag           = rsp.out_tag;
   assign rsp_out_bytes         = rsp.out_bytes;
   assign rsp_last_of_run       = rsp.last_of_run;
   assign rsp_queue_count       = rsp.queue_count;
   assign rsp_queue_total_bytes = rsp.queue_total_bytes;
   assign rsp_timer_request     = rsp.timer_request;

endmodule

`default_nettype wire

// File: rtl/bdtq_csr.sv
// Configuration registers and the registered byte limit.
// Depends on bdtq_pkg.
`default_nettype none

module bdtq_csr import bdtq_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output cfg_type               cfg
);

   logic [LIMIT_W-1:0]   limit_ff;
   logic [MEAN_W-1:0]    mean_ff;
   logic                 in_bytes_ff;
   logic                 front_ff;
   logic [TIMEOUT_W-1:0] timeout_ff;
   logic [BATCH_W-1:0]   batch_ff;
   logic [LIM_W-1:0]     lim_bytes_ff;
   logic [LIM_W-1:0]     lim_bytes_in;
   logic                 wr;

   assign csr_ready    = 1'b1;
   assign wr           = csr_valid && csr_ready;
   assign lim_bytes_in = LIM_W'(limit_ff) * LIM_W'(mean_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LIMIT_W'(50);
         mean_ff      <= MEAN_W'(500);
         in_bytes_ff  <= 1'b0;
         front_ff     <= 1'b0;
         timeout_ff   <= TIMEOUT_W'(1000);
         batch_ff     <= '0;
         lim_bytes_ff <= LIM_W'(25000);
      end else begin
         lim_bytes_ff <= lim_bytes_in;
         if (wr) begin
            case (csr_index)
               CSR_LIMIT_PACKETS:    limit_ff    <= csr_data[LIMIT_W-1:0];
               CSR_MEAN_PACKET_SIZE: mean_ff     <= csr_data[MEAN_W-1:0];
               CSR_COUNT_IN_BYTES:   in_bytes_ff <= csr_data[0];
               CSR_DROP_FROM_FRONT:  front_ff    <= csr_data[0];
               CSR_BATCH_TIMEOUT:    timeout_ff  <= csr_data[TIMEOUT_W-1:0];
               CSR_BATCH_BYTES:      batch_ff    <= csr_data[BATCH_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      cfg.limit_packets   = limit_ff;
      cfg.count_in_bytes  = in_bytes_ff;
      cfg.drop_from_front = front_ff;
      cfg.batch_timeout   = timeout_ff;
      cfg.batch_bytes     = batch_ff;
      cfg.lim_bytes       = lim_bytes_ff;
   end

endmodule

`default_nettype wire

// File: rtl/bdtq_front.sv
// Front end: takes requests, classifies the action, drops undefined codes.
// Depends on bdtq_pkg; feeds bdtq_cmd_queue.
`default_nettype none

module bdtq_front import bdtq_pkg::*; (
   input  logic                req_push,
   output logic                req_full,
   input  logic [ACTION_W-1:0] req_action,
   input  logic [TAG_W-1:0]    req_in_tag,
   input  logic [BYTES_W-1:0]  req_in_bytes,
   input  logic [TIME_W-1:0]   req_now_time,
   input  logic                q_full,
   output logic                q_push,
   output cmd_type             q_cmd
);

   logic known;

   assign req_full = q_full;

   always_comb begin
      known    = 1'b1;
      q_cmd.op = OP_ENQUEUE;
      case (req_action)
         ACT_ENQUEUE: q_cmd.op = OP_ENQUEUE;
         ACT_DEQUEUE: q_cmd.op = OP_DEQUEUE;
         ACT_SHRINK:  q_cmd.op = OP_SHRINK;
         default:     known    = 1'b0;
      endcase
      q_cmd.tag      = req_in_tag;
      q_cmd.bytes    = req_in_bytes;
      q_cmd.now_time = req_now_time;
      // accept an undefined action but drop it here
      q_push = req_push && !q_full && known;
   end

endmodule

`default_nettype wire

// File: rtl/bdtq_cmd_queue.sv
// Two-entry command queue between the front and the back.
// Depends on bdtq_pkg.
`default_nettype none

module bdtq_cmd_queue import bdtq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output cmd_type head_cmd
);

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       do_push, do_pop;

   assign full     = (fill_ff == 2'd2);
   assign empty    = (fill_ff == 2'd0);
   assign head_cmd = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// File: rtl/bdtq_back.sv
// Back end: packet store, queue state, send pacing and the result register.
// Depends on bdtq_pkg; takes commands from bdtq_cmd_queue.
`default_nettype none

module bdtq_back import bdtq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    cmd_empty,
   input  cmd_type cmd_head,
   output logic    cmd_pop,
   input  logic    rsp_pop,
   output logic    rsp_empty,
   output rsp_type rsp
);

   typedef enum logic {ST_IDLE, ST_EXEC} state_type;

   typedef struct packed {
      logic [TAG_W-1:0]   tag;
      logic [BYTES_W-1:0] size;
   } entry_type;

   localparam logic [IDX_W-1:0] SHRINK_MAX = IDX_W'(QUEUE_DEPTH - 1);

   entry_type             mem [QUEUE_DEPTH];
   entry_type             rd_ff;
   entry_type             wr_entry;
   logic [IDX_W-1:0]      wr_addr, rd_addr;
   logic                  mem_we, mem_re;

   state_type             state_ff, state_in;
   cmd_type               cmd_ff, cmd_in;
   logic [IDX_W-1:0]      head_ff, head_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [TOTAL_W-1:0]    total_ff, total_in;
   logic                  burst_ff, burst_in;
   logic [TIME_W-1:0]     last_send_ff, last_send_in;
   logic                  pending_ff, pending_in;
   logic [IDX_W-1:0]      k_ff, k_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic                  out_free;
   logic                  emit;
   rsp_type               rsp_new;
   logic [LIM_W-1:0]      enq_sum;
   logic                  overflow;
   logic [TIME_W-1:0]     elapsed;
   logic                  defer;
   logic                  over_limit;
   logic                  shrink_more;
   logic                  shrink_tail;

   assign out_free  = !rsp_valid_ff || rsp_pop;
   assign rsp_empty = !rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_comb begin
      enq_sum  = LIM_W'(total_ff) + LIM_W'(cmd_ff.bytes);
      overflow = cfg.count_in_bytes ? (enq_sum >= cfg.lim_bytes)
               : ((CNT_W+1)'(count_ff) + (CNT_W+1)'(1) >= (CNT_W+1)'(cfg.limit_packets));
      if (count_ff == CNT_W'(QUEUE_DEPTH)) begin
         overflow = 1'b1;
      end
      elapsed     = cmd_ff.now_time - last_send_ff;
      defer       = !burst_ff && (elapsed < cfg.batch_timeout)
                 && (BATCH_W'(total_ff) < cfg.batch_bytes);
      over_limit  = cfg.count_in_bytes ? (LIM_W'(total_ff) > cfg.lim_bytes)
                  : (count_ff > cfg.limit_packets);
      shrink_more = (k_ff < SHRINK_MAX) && (count_ff != '0) && over_limit;
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      total_in     = total_ff;
      burst_in     = burst_ff;
      last_send_in = last_send_ff;
      pending_in   = pending_ff;
      k_in         = k_ff;
      cmd_pop      = 1'b0;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      wr_addr      = head_ff + count_ff[IDX_W-1:0];
      wr_entry     = '{tag: cmd_ff.tag, size: cmd_ff.bytes};
      emit         = 1'b0;
      rsp_new      = '{result_kind: KIND_ACCEPTED, last_of_run: 1'b1, default: '0};

      case (state_ff)
         ST_IDLE: begin
            // load the next command and start the store read it needs
            if (!cmd_empty) begin
               cmd_pop  = 1'b1;
               cmd_in   = cmd_head;
               k_in     = '0;
               mem_re   = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = ST_IDLE;
               case (cmd_ff.op)
                  OP_ENQUEUE: begin
                     if (!overflow) begin
                        mem_we   = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                        total_in = total_ff + TOTAL_W'(cmd_ff.bytes);
                     end else if (cfg.drop_from_front && count_ff != '0) begin
                        // head was read at load; drop it and append the newcomer at the tail
                        mem_we              = 1'b1;
                        head_in             = head_ff + IDX_W'(1);
                        total_in            = total_ff - TOTAL_W'(rd_ff.size)
                                            + TOTAL_W'(cmd_ff.bytes);
                        rsp_new.result_kind = KIND_DROPPED;
                        rsp_new.out_tag     = rd_ff.tag;
                        rsp_new.out_bytes   = rd_ff.size;
                     end else begin
                        rsp_new.result_kind = KIND_DROPPED;
                        rsp_new.out_tag     = cmd_ff.tag;
                        rsp_new.out_bytes   = cmd_ff.bytes;
                     end
                  end
                  OP_DEQUEUE: begin
                     if (defer) begin
                        pending_in            = 1'b1;
                        rsp_new.result_kind   = KIND_DEFERRED;
                        rsp_new.timer_request = !pending_ff;
                     end else begin
                        last_send_in = cmd_ff.now_time;
                        pending_in   = 1'b0;
                        if (count_ff == '0) begin
                           burst_in            = 1'b0;
                           rsp_new.result_kind = KIND_EMPTY;
                        end else begin
                           head_in             = head_ff + IDX_W'(1);
                           count_in            = count_ff - CNT_W'(1);
                           total_in            = total_ff - TOTAL_W'(rd_ff.size);
                           burst_in            = (count_ff != CNT_W'(1));
                           rsp_new.result_kind = KIND_SENT;
                           rsp_new.out_tag     = rd_ff.tag;
                           rsp_new.out_bytes   = rd_ff.size;
                        end
                     end
                  end
                  OP_SHRINK: begin
                     if (shrink_more) begin
                        if (cfg.drop_from_front) begin
                           head_in = head_ff + IDX_W'(1);
                        end
                        count_in            = count_ff - CNT_W'(1);
                        total_in            = total_ff - TOTAL_W'(rd_ff.size);
                        k_in                = k_ff + IDX_W'(1);
                        mem_re              = 1'b1;
                        state_in            = ST_EXEC;
                        rsp_new.result_kind = KIND_DROPPED;
                        rsp_new.out_tag     = rd_ff.tag;
                        rsp_new.out_bytes   = rd_ff.size;
                        rsp_new.last_of_run = 1'b0;
                     end else begin
                        rsp_new.result_kind = KIND_SHRINK_DONE;
                     end
                  end
                  default: emit = 1'b0;
               endcase
            end
         end
         default: state_in = ST_IDLE;
      endcase

      rsp_new.queue_count       = count_in;
      rsp_new.queue_total_bytes = total_in;
      rsp_in       = emit ? rsp_new : rsp_ff;
      rsp_valid_in = emit || (rsp_valid_ff && !rsp_pop);

      // read address follows the state as it will be after this cycle
      shrink_tail = (cmd_in.op == OP_SHRINK) && !cfg.drop_from_front;
      rd_addr     = shrink_tail ? head_in + count_in[IDX_W-1:0] - IDX_W'(1) : head_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         total_ff     <= '0;
         burst_ff     <= 1'b0;
         last_send_ff <= '0;
         pending_ff   <= 1'b0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         burst_ff     <= burst_in;
         last_send_ff <= last_send_in;
         pending_ff   <= pending_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff <= cmd_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_entry;
      end
      if (mem_re) begin
         rd_ff <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: rtl/bdtq_checker.sv
// Port-level checks for the batching drop-tail queue, bound to the top level.
// Depends on bdtq_pkg and batching_drop_tail_queue_top.
`default_nettype none

module bdtq_checker import bdtq_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_empty,
   input logic                  rsp_pop,
   input logic [KIND_W-1:0]     rsp_result_kind,
   input logic [TAG_W-1:0]      rsp_out_tag,
   input logic [BYTES_W-1:0]    rsp_out_bytes,
   input logic                  rsp_last_of_run,
   input logic [CNT_W-1:0]      rsp_queue_count,
   input logic [TOTAL_W-1:0]    rsp_queue_total_bytes,
   input logic                  rsp_timer_request
);

   // a waiting result stays until popped
   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) && $past(!rsp_empty && !rsp_pop) |-> !rsp_empty)
      else $error("result withdrawn before pop");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) && $past(!rsp_empty && !rsp_pop)
      |-> $stable(rsp_result_kind) && $stable(rsp_out_tag) && $stable(rsp_out_bytes)
          && $stable(rsp_queue_count) && $stable(rsp_queue_total_bytes))
      else $error("result changed while waiting");

   // a timer is only asked for by a deferral
   a_timer_on_defer: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_timer_request |-> rsp_result_kind == KIND_DEFERRED)
      else $error("timer request outside a deferral");

   // only shrink drops continue a run
   a_run_continues_on_drop: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_last_of_run |-> rsp_result_kind == KIND_DROPPED)
      else $error("non-final result that is not a drop");

   // an empty answer leaves nothing queued
   a_empty_means_zero: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_result_kind == KIND_EMPTY
      |-> rsp_queue_count == '0 && rsp_queue_total_bytes == '0)
      else $error("empty result with packets queued");

endmodule

bind batching_drop_tail_queue_top bdtq_checker u_bdtq_checker (.*);

`default_nettype wire
